// File: rtl/uecp_pkg.sv
// ----------------------------------------------------------------------------
// UECP frame assembler package
// Shared constants, queue entry type and the CRC-16-CCITT byte update.
// ----------------------------------------------------------------------------
package uecp_pkg;

  localparam logic [7:0]  START_BYTE = 8'hFE;
  localparam logic [7:0]  STOP_BYTE  = 8'hFF;
  localparam logic [7:0]  ESC_BYTE   = 8'hFD;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SITE_ADDRESS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_NUMBER = 2'd1;

  // one classified item, handed from the front to the back
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] len;
    logic       first;
    logic       close;   // emit CRC and stop byte after this item
  } frame_job_t;

  // CRC-16-CCITT (poly 0x1021), one byte, table-free form
  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x      = {c[7:0], c[15:8]};
    x[7:0] = x[7:0] ^ b;
    x      = x ^ {12'd0, x[7:4]};
    x      = x ^ {x[3:0], 12'd0};
    x      = x ^ {3'd0, x[7:0], 5'd0};
    return x;
  endfunction

endpackage

// File: rtl/uecp_intf.sv
// ----------------------------------------------------------------------------
// UECP frame assembler channels
// Input item, output byte and configuration write channels.
// ----------------------------------------------------------------------------
interface uecp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] msg_length;
  logic       first_byte;
  logic       final_byte;

  modport source (output valid, data_byte, msg_length, first_byte, final_byte,
                  input ready);
  modport sink (input valid, data_byte, msg_length, first_byte, final_byte,
                output ready);
endinterface

interface uecp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink (input valid, out_byte, run_last, output ready);
endinterface

interface uecp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/uecp_front.sv
// ----------------------------------------------------------------------------
// UECP front end
// Accepts input items, tracks the open frame and queues the items that
// produce output, with the close decision already made.
// ----------------------------------------------------------------------------
module uecp_front
  import uecp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  uecp_in_if.sink     byte_in,
  input  logic        q_full,
  output logic        q_push,
  output frame_job_t  q_job
);

  logic frame_open;
  logic frame_open_next;
  logic accept;
  logic empty_frame;

  assign byte_in.ready = !q_full;
  assign accept        = byte_in.valid && byte_in.ready;
  assign empty_frame   = (byte_in.msg_length == 8'd0);

  always_comb begin
    q_job.data  = byte_in.data_byte;
    q_job.len   = byte_in.msg_length;
    q_job.first = byte_in.first_byte;
    q_job.close = byte_in.first_byte ? (empty_frame || byte_in.final_byte)
                                     : byte_in.final_byte;
    // bytes outside a frame are dropped here
    q_push          = accept && (byte_in.first_byte || frame_open);
    frame_open_next = frame_open;
    if (q_push) begin
      frame_open_next = !q_job.close;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
    end else begin
      frame_open <= frame_open_next;
    end
  end

endmodule

// File: rtl/uecp_queue.sv
// ----------------------------------------------------------------------------
// UECP job queue
// Small FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module uecp_queue
  import uecp_pkg::*;
#(
  parameter int DEPTH = 2
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  frame_job_t push_job,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output frame_job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  frame_job_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/uecp_back.sv
// ----------------------------------------------------------------------------
// UECP back end
// Byte sequencer: header, data, CRC and stop bytes with escape stuffing,
// one byte per cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module uecp_back
  import uecp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  frame_job_t  q_job,
  output logic        q_pop,
  uecp_cfg_if.sink    cfg,
  uecp_out_if.source  frame_out
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_START  = 4'd1;
  localparam logic [3:0] PH_ADDR_H = 4'd2;
  localparam logic [3:0] PH_ADDR_L = 4'd3;
  localparam logic [3:0] PH_SEQ    = 4'd4;
  localparam logic [3:0] PH_LEN    = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_CRC_H  = 4'd7;
  localparam logic [3:0] PH_CRC_L  = 4'd8;
  localparam logic [3:0] PH_STOP   = 4'd9;

  logic [15:0] site_address;
  logic [7:0]  sequence_number;
  logic [15:0] running_check;
  logic [3:0]  phase;
  logic [3:0]  phase_next;
  frame_job_t  job;
  logic        esc_pending;
  logic [1:0]  esc_code;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  logic [7:0]  cur_byte;
  logic [15:0] crc_final;
  logic        checked;
  logic        stuffable;
  logic        need_esc;
  logic        step_done;
  logic        job_end;
  logic        advance;
  logic [7:0]  emit_byte;

  assign cfg.ready          = 1'b1;
  assign frame_out.valid    = out_valid;
  assign frame_out.out_byte = out_byte;
  assign frame_out.run_last = out_last;

  assign crc_final = ~running_check;

  always_comb begin
    unique case (phase)
      PH_START:  cur_byte = START_BYTE;
      PH_ADDR_H: cur_byte = site_address[15:8];
      PH_ADDR_L: cur_byte = site_address[7:0];
      PH_SEQ:    cur_byte = sequence_number;
      PH_LEN:    cur_byte = job.len;
      PH_DATA:   cur_byte = job.data;
      PH_CRC_H:  cur_byte = crc_final[15:8];
      PH_CRC_L:  cur_byte = crc_final[7:0];
      PH_STOP:   cur_byte = STOP_BYTE;
      default:   cur_byte = 8'h00;
    endcase

    unique case (phase)
      PH_START:  phase_next = PH_ADDR_H;
      PH_ADDR_H: phase_next = PH_ADDR_L;
      PH_ADDR_L: phase_next = PH_SEQ;
      PH_SEQ:    phase_next = PH_LEN;
      PH_LEN:    phase_next = (job.len == 8'd0) ? PH_CRC_H : PH_DATA;
      PH_DATA:   phase_next = job.close ? PH_CRC_H : PH_IDLE;
      PH_CRC_H:  phase_next = PH_CRC_L;
      PH_CRC_L:  phase_next = PH_STOP;
      default:   phase_next = PH_IDLE;
    endcase

    checked   = (phase == PH_ADDR_H) || (phase == PH_ADDR_L) || (phase == PH_SEQ) ||
                (phase == PH_LEN) || (phase == PH_DATA);
    stuffable = checked || (phase == PH_CRC_H) || (phase == PH_CRC_L);
    need_esc  = stuffable && !esc_pending && (cur_byte >= ESC_BYTE);
    step_done = !need_esc;
    job_end   = step_done && (phase_next == PH_IDLE);
    advance   = (phase != PH_IDLE) && (!out_valid || frame_out.ready);
    emit_byte = esc_pending ? {6'd0, esc_code} : (need_esc ? ESC_BYTE : cur_byte);
    // next job starts right behind the last byte of the current one
    q_pop     = q_valid && ((phase == PH_IDLE) || (advance && job_end));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      site_address    <= 16'd0;
      sequence_number <= 8'd0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_SITE_ADDRESS) begin
        site_address <= cfg.data;
      end else if (cfg.index == REG_SEQUENCE_NUMBER) begin
        sequence_number <= cfg.data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      esc_pending   <= 1'b0;
      out_valid     <= 1'b0;
      running_check <= CRC_INIT;
    end else begin
      if (advance) begin
        out_valid   <= 1'b1;
        esc_pending <= need_esc;
      end else if (frame_out.ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        phase <= q_job.first ? PH_START : PH_DATA;
      end else if (advance && !need_esc) begin
        phase <= phase_next;
      end
      // a new frame reloads the CRC; otherwise the last data byte carries over
      if (q_pop && q_job.first) begin
        running_check <= CRC_INIT;
      end else if (advance && checked && !esc_pending) begin
        running_check <= crc_step(running_check, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= emit_byte;
      out_last <= job_end;
      if (need_esc) begin
        // 0xFD/0xFE/0xFF -> 0/1/2
        esc_code <= cur_byte[1:0] - 2'd1;
      end
    end
    if (q_pop) begin
      job <= q_job;
    end
  end

endmodule

// File: rtl/uecp_frame_assembler_unit.sv
// ----------------------------------------------------------------------------
// UECP frame assembler
// Path: an accepted item goes through the queue into the byte sequencer of the
// back end, which emits its bytes through the registered output stage.
// Throughput: one byte per cycle while the receiver is ready; an item gives
// 1-2 bytes mid-frame, up to 7 when closing, up to 16 as a one-byte frame.
// Reset: no frame open, CRC 0xFFFF, registers zero, queue and output empty.
// ----------------------------------------------------------------------------
module uecp_frame_assembler_unit
  import uecp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)(
  input  logic        clk,
  input  logic        rst,
  uecp_in_if.sink     byte_in,
  uecp_cfg_if.sink    cfg,
  uecp_out_if.source  frame_out
);

  logic       q_full;
  logic       q_push;
  frame_job_t q_push_job;
  logic       q_pop;
  logic       q_valid;
  frame_job_t q_head_job;

  uecp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_push_job)
  );

  uecp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  uecp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_head_job),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .frame_out (frame_out)
  );

endmodule

// File: sim/uecp_frame_assembler_unit_test.sv
// ----------------------------------------------------------------------------
// UECP frame assembler testbench
// Drives message bytes with first/final marks and register writes. A local
// frame model predicts every stuffed output byte and its run_last flag, and
// each byte that leaves the block is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module uecp_frame_assembler_unit_test
  import uecp_pkg::*;
();

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_BYTES_PER_ITEM = 16;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } frame_byte_t;

  // Frame model: tracks registers, CRC and open frame; holds expected bytes
  class uecp_frame_model;
    logic [15:0] site_address;
    logic [7:0]  sequence_number;
    logic [15:0] crc_reg;
    bit          frame_open;
    frame_byte_t burst[$];
    frame_byte_t expected_bytes[$];
    int          errors;

    function new();
      site_address = '0;
      sequence_number = '0;
      crc_reg = 16'hFFFF;
      frame_open = 1'b0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // CRC-16-CCITT, bit serial, MSB first
    function logic [15:0] ccitt_update(input logic [15:0] c, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ 16'h1021;
      end
      return c;
    endfunction

    function void put_raw(input logic [7:0] b);
      if (burst.size() < MAX_BYTES_PER_ITEM) burst.push_back('{b, 1'b0});
    endfunction

    function void put_stuffed(input logic [7:0] b);
      if (b >= ESC_BYTE) begin
        put_raw(ESC_BYTE);
        put_raw(b - ESC_BYTE);
      end else begin
        put_raw(b);
      end
    endfunction

    function void put_checked(input logic [7:0] b);
      crc_reg = ccitt_update(crc_reg, b);
      put_stuffed(b);
    endfunction

    function void close_frame();
      logic [15:0] c;
      c = ~crc_reg;
      put_stuffed(c[15:8]);
      put_stuffed(c[7:0]);
      put_raw(STOP_BYTE);
      frame_open = 1'b0;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] wdata);
      if (idx == REG_SITE_ADDRESS) site_address = wdata;
      else if (idx == REG_SEQUENCE_NUMBER) sequence_number = wdata[7:0];
    endfunction

    function void note_item(input logic [7:0] data, input logic [7:0] len,
                            input bit first, input bit fin);
      burst.delete();
      if (first) begin
        crc_reg = 16'hFFFF;
        frame_open = 1'b1;
        put_raw(START_BYTE);
        put_checked(site_address[15:8]);
        put_checked(site_address[7:0]);
        put_checked(sequence_number);
        put_checked(len);
        if (len == 0) begin
          close_frame();
        end else begin
          put_checked(data);
          if (fin) close_frame();
        end
      end else if (frame_open) begin
        put_checked(data);
        if (fin) close_frame();
      end
      if (burst.size() > 0) burst[burst.size()-1].run_last = 1'b1;
      foreach (burst[i]) expected_bytes.push_back(burst[i]);
    endfunction

    task check_byte(input logic [7:0] b, input logic last);
      frame_byte_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h run_last %0b", b, last));
        return;
      end
      e = expected_bytes.pop_front();
      if (b !== e.out_byte)
        report($sformatf("out_byte %02h, predicted %02h", b, e.out_byte));
      if (last !== e.run_last)
        report($sformatf("run_last %0b, predicted %0b (byte %02h)", last, e.run_last, b));
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  uecp_in_if  byte_in();
  uecp_cfg_if cfg_bus();
  uecp_out_if frame_out();

  uecp_frame_assembler_unit dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in),
    .cfg(cfg_bus),
    .frame_out(frame_out)
  );

  uecp_frame_model model = new();

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_trigger = 0;
  int hold_left = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_trigger != 0) begin
      hold_left = hold_trigger;
      hold_trigger = 0;
    end
    if (hold_left > 0) begin
      frame_out.ready = 1'b0;
      hold_left--;
    end else begin
      frame_out.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && frame_out.valid && frame_out.ready)
      model.check_byte(frame_out.out_byte, frame_out.run_last);
  end

  // called at a falling edge; leaves valid high after the transaction
  task send_item(input logic [7:0] data, input logic [7:0] len, input bit first,
                 input bit fin);
    while ($urandom_range(99) < idle_pct) begin
      byte_in.valid = 1'b0;
      @(negedge clk);
    end
    byte_in.valid = 1'b1;
    byte_in.data_byte = data;
    byte_in.msg_length = len;
    byte_in.first_byte = first;
    byte_in.final_byte = fin;
    do @(posedge clk); while (!byte_in.ready);
    model.note_item(data, len, first, fin);
    @(negedge clk);
  endtask

  task wait_drained();
    byte_in.valid = 1'b0;
    while (model.pending() != 0) @(negedge clk);
    // a stray byte yields nothing, so give the pipeline time to empty
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] wdata);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = wdata;
    do @(posedge clk); while (!cfg_bus.ready);
    model.set_register(idx, wdata);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function logic [7:0] rand_data();
    if ($urandom_range(9) < 3) return 8'(ESC_BYTE + $urandom_range(2));
    return 8'($urandom_range(255));
  endfunction

  task directed_items();
    // reset register values
    send_item(8'h12, 8'h05, 1'b0, 1'b0);      // outside a frame: ignored
    send_item(8'h34, 8'h02, 1'b1, 1'b0);
    send_item(8'hFD, 8'h00, 1'b0, 1'b1);
    wait_drained();
    write_register(REG_SITE_ADDRESS, 16'hFFFF);
    write_register(REG_SEQUENCE_NUMBER, 16'h00FF);
    send_item(8'hFE, 8'hFF, 1'b1, 1'b1);      // one-byte frame, worst expansion
    send_item(8'hAB, 8'h00, 1'b1, 1'b1);      // empty frame, data ignored
    send_item(8'h00, 8'h00, 1'b1, 1'b0);      // empty frame without final mark
    send_item(8'h55, 8'h00, 1'b0, 1'b1);      // final outside a frame
    send_item(8'hFD, 8'h03, 1'b1, 1'b0);      // escape of all three codes
    send_item(8'hFE, 8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 8'h00, 1'b0, 1'b1);
    send_item(8'h00, 8'h05, 1'b1, 1'b0);
    send_item(8'h80, 8'h00, 1'b0, 1'b0);
    send_item(8'h01, 8'h02, 1'b1, 1'b0);      // restarts over the open frame
    send_item(8'hFF, 8'h00, 1'b0, 1'b1);
    send_item(8'h7F, 8'h02, 1'b1, 1'b0);      // more bytes than the length says
    send_item(8'h11, 8'h00, 1'b0, 1'b0);
    send_item(8'h22, 8'h00, 1'b0, 1'b0);
    send_item(8'hFD, 8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 8'h80, 1'b1, 1'b0);
    send_item(8'h00, 8'hFF, 1'b0, 1'b1);      // length ignored after the first
  endtask

  task random_frames(input int n_items);
    int sent;
    int len;
    int nbytes;
    bit abandon;
    bit open_frame;
    sent = 0;
    open_frame = 1'b0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 8) begin
        send_item(rand_data(), 8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        if (open_frame) sent++;
      end else if ($urandom_range(99) < 7) begin
        send_item(rand_data(), 8'h00, 1'b1, 1'($urandom_range(1)));
        sent++;
        open_frame = 1'b0;
      end else begin
        len = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1, 6);
        if (len == 0) nbytes = 1;
        else if ($urandom_range(9) < 7) nbytes = (len > 8) ? $urandom_range(1, 8) : len;
        else nbytes = $urandom_range(1, 8);
        abandon = ($urandom_range(19) == 0);
        for (int i = 0; i < nbytes; i++) begin
          send_item(rand_data(), (i == 0) ? 8'(len) : 8'($urandom_range(255)),
                    i == 0, (i == nbytes - 1) && !abandon);
        end
        sent += nbytes;
        open_frame = abandon && (len != 0);
      end
    end
  endtask

  task run_phase(input int idle, input int stall, input logic [15:0] addr,
                 input logic [7:0] seq, input int n_items, input bit hold);
    wait_drained();
    write_register(REG_SITE_ADDRESS, addr);
    write_register(REG_SEQUENCE_NUMBER, {8'($urandom_range(255)), seq});
    idle_pct = idle;
    stall_pct = stall;
    if (hold) hold_trigger = 300;
    random_frames(n_items / 2);
    wait_drained();
    random_frames(n_items - n_items / 2);
  endtask

  initial begin
    rst = 1'b1;
    byte_in.valid = 1'b0;
    byte_in.data_byte = '0;
    byte_in.msg_length = '0;
    byte_in.first_byte = 1'b0;
    byte_in.final_byte = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_SITE_ADDRESS;
    cfg_bus.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_items();
    run_phase(0, 0, 16'h0000, 8'h00, 85, 1'b1);
    run_phase(84, 0, 16'($urandom_range(65535)), 8'($urandom_range(255)), 85, 1'b0);
    run_phase(0, 84, 16'hFDFE, 8'hFD, 85, 1'b1);
    run_phase(12, 12, 16'($urandom_range(65535)), 8'($urandom_range(255)), 85, 1'b0);

    wait_drained();
    if (model.pending() != 0)
      model.report($sformatf("%0d predicted bytes never arrived", model.pending()));
    if (model.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
